FILE: hw/rtl/euq_pkg.sv
// ----------------------------------------------------------------------------
// euq_pkg
// Shared types, constants and arithmetic helpers for the Euler angle to
// quaternion converter.
// ----------------------------------------------------------------------------
package euq_pkg;

  // CORDIC datapath width: Q2.30 values plus headroom
  localparam int CW = 34;
  localparam int TABLE_LEN = 24;
  localparam int STEPS_DEF = 16;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [14:0] THRESH_RESET = 15'd31858;
  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  // Per-beat control that travels alongside the data
  typedef struct packed {
    logic vld;
    logic ok;
  } ctl_t;

  // atan(2^-i) in turn units (2^32 per turn)
  function automatic logic signed [CW-1:0] atan_turns(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      default: t = 32'h00000000;
    endcase
    return $signed({2'b00, t});
  endfunction

  // Q2.30 product, round half up
  function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b + 68'sd536870912;
    return p[CW+29:30];
  endfunction

  // Q2.30 sum to saturated Q1.14, round half up
  function automatic logic signed [15:0] to_q14(input logic signed [CW:0] v);
    logic signed [CW:0] t;
    logic signed [CW:0] r;
    logic signed [15:0] q;
    t = v + 35'sd32768;
    r = t >>> 16;
    if (r > 35'sd16384) begin
      q = Q14_ONE;
    end else if (r < -35'sd16384) begin
      q = -Q14_ONE;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

endpackage

FILE: hw/rtl/euq_cordic.sv
// ----------------------------------------------------------------------------
// euq_cordic
// Rotation-mode CORDIC, one register stage per iteration, giving cosine and
// sine of a half angle in Q2.30.
// ----------------------------------------------------------------------------
module euq_cordic #(
  parameter int NSTEP = euq_pkg::STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [euq_pkg::CW-1:0]  phi,
  output logic signed [euq_pkg::CW-1:0]  cos_o,
  output logic signed [euq_pkg::CW-1:0]  sin_o
);

  localparam int CW = euq_pkg::CW;

  logic signed [CW-1:0] x_r [NSTEP];
  logic signed [CW-1:0] y_r [NSTEP];
  logic signed [CW-1:0] z_r [NSTEP-1];

  genvar i;
  generate
    for (i = 0; i < NSTEP; i++) begin : g_step
      logic signed [CW-1:0] x_in, y_in, z_in;
      logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
      logic signed [CW-1:0] dx, dy, at;

      // pick stage inputs
      if (i == 0) begin : g_first
        assign x_in = euq_pkg::GAIN_Q30;
        assign y_in = '0;
        assign z_in = phi;
      end else begin : g_next
        assign x_in = x_r[i-1];
        assign y_in = y_r[i-1];
        assign z_in = z_r[i-1];
      end

      // rotate one micro-step toward zero residual angle
      always_comb begin
        dx = y_in >>> i;
        dy = x_in >>> i;
        at = euq_pkg::atan_turns(5'(i));
        if (!z_in[CW-1]) begin
          x_nxt = x_in - dx;
          y_nxt = y_in + dy;
          z_nxt = z_in - at;
        end else begin
          x_nxt = x_in + dx;
          y_nxt = y_in - dy;
          z_nxt = z_in + at;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i] <= x_nxt;
          y_r[i] <= y_nxt;
        end
      end

      if (i < NSTEP - 1) begin : g_z
        always_ff @(posedge clk) begin
          if (en) begin
            z_r[i] <= z_nxt;
          end
        end
      end
    end
  endgenerate

  assign cos_o = x_r[NSTEP-1];
  assign sin_o = y_r[NSTEP-1];

endmodule

FILE: hw/rtl/euq_quat.sv
// ----------------------------------------------------------------------------
// euq_quat
// Three-stage product network: pair products, triple products, then sums
// with rounding, saturation and gating to zero on refusal.
// ----------------------------------------------------------------------------
module euq_quat (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  euq_pkg::ctl_t                 ctl_in,
  input  logic signed [euq_pkg::CW-1:0] cx,
  input  logic signed [euq_pkg::CW-1:0] sx,
  input  logic signed [euq_pkg::CW-1:0] cy,
  input  logic signed [euq_pkg::CW-1:0] sy,
  input  logic signed [euq_pkg::CW-1:0] cz,
  input  logic signed [euq_pkg::CW-1:0] sz,
  output euq_pkg::ctl_t                 ctl_out,
  output logic signed [15:0]            quat_w,
  output logic signed [15:0]            quat_x,
  output logic signed [15:0]            quat_y,
  output logic signed [15:0]            quat_z
);

  localparam int CW = euq_pkg::CW;

  euq_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r;

  logic signed [CW-1:0] pcc_r, pss_r, psc_r, pcs_r, cz_r, sz_r;
  logic signed [CW-1:0] t_ccc_r, t_sss_r, t_scc_r, t_css_r;
  logic signed [CW-1:0] t_csc_r, t_scs_r, t_ccs_r, t_ssc_r;
  logic signed [15:0]   w_r, x_r, y_r, z_r;
  logic signed [15:0]   w_nxt, x_nxt, y_nxt, z_nxt;

  // advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  // stage 1: pair products
  always_ff @(posedge clk) begin
    if (en) begin
      pcc_r <= euq_pkg::mul30(cx, cy);
      pss_r <= euq_pkg::mul30(sx, sy);
      psc_r <= euq_pkg::mul30(sx, cy);
      pcs_r <= euq_pkg::mul30(cx, sy);
      cz_r  <= cz;
      sz_r  <= sz;
    end
  end

  // stage 2: triple products
  always_ff @(posedge clk) begin
    if (en) begin
      t_ccc_r <= euq_pkg::mul30(pcc_r, cz_r);
      t_sss_r <= euq_pkg::mul30(pss_r, sz_r);
      t_scc_r <= euq_pkg::mul30(psc_r, cz_r);
      t_css_r <= euq_pkg::mul30(pcs_r, sz_r);
      t_csc_r <= euq_pkg::mul30(pcs_r, cz_r);
      t_scs_r <= euq_pkg::mul30(psc_r, sz_r);
      t_ccs_r <= euq_pkg::mul30(pcc_r, sz_r);
      t_ssc_r <= euq_pkg::mul30(pss_r, cz_r);
    end
  end

  // stage 3: sums, rounding, saturation, gating
  always_comb begin
    w_nxt = euq_pkg::to_q14(35'(t_ccc_r) + 35'(t_sss_r));
    x_nxt = euq_pkg::to_q14(35'(t_scc_r) - 35'(t_css_r));
    y_nxt = euq_pkg::to_q14(35'(t_csc_r) + 35'(t_scs_r));
    z_nxt = euq_pkg::to_q14(35'(t_ccs_r) - 35'(t_ssc_r));
    if (!ctl2_r.ok) begin
      w_nxt = '0;
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_out = ctl3_r;
  assign quat_w  = w_r;
  assign quat_x  = x_r;
  assign quat_y  = y_r;
  assign quat_z  = z_r;

endmodule

FILE: hw/rtl/euler_to_quaternion_gated.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_gated
// Pipeline: NSTEP CORDIC stages, then pair products, triple products and
//   output sums, each stage registered.
// Throughput: one beat per cycle; the whole pipeline holds while a result
//   waits on out_ready.
// Reset: synchronous, active low; clears all valid bits and loads the
//   gimbal threshold with its default.
// ----------------------------------------------------------------------------
module euler_to_quaternion_gated #(
  parameter int CORDIC_STEPS = euq_pkg::STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_yaw_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  input  logic               cfg_wr_en,
  input  logic [14:0]        cfg_wr_data
);

  localparam int CW = euq_pkg::CW;
  localparam int NSTEP = (CORDIC_STEPS > euq_pkg::TABLE_LEN) ?
                         euq_pkg::TABLE_LEN : CORDIC_STEPS;

  logic [14:0]          thresh_r;
  euq_pkg::ctl_t        ctl_r [NSTEP];
  euq_pkg::ctl_t        ctl_in, ctl_q;
  logic                 en;
  logic signed [16:0]   pitch_ext, apitch;
  logic signed [CW-1:0] phi_x, phi_y, phi_z;
  logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;

  // hold the whole pipe while the output beat is stalled
  assign en       = !ctl_q.vld || out_ready;
  assign in_ready = en;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= euq_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // gimbal check and half-angle setup
  always_comb begin
    pitch_ext = 17'(in_pitch_angle);
    apitch    = pitch_ext[16] ? -pitch_ext : pitch_ext;
    ctl_in.vld = in_valid;
    ctl_in.ok  = apitch < $signed({2'b00, thresh_r});
    phi_x = CW'($signed({in_roll_angle, 15'b0}));
    phi_y = CW'($signed({in_yaw_angle, 15'b0}));
    phi_z = CW'($signed({-pitch_ext, 15'b0}));
  end

  // advance control alongside the CORDIC stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTEP; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= ctl_in;
      for (int k = 1; k < NSTEP; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  euq_cordic #(.NSTEP(NSTEP)) u_cordic_x (
    .clk(clk), .en(en), .phi(phi_x), .cos_o(cx), .sin_o(sx)
  );
  euq_cordic #(.NSTEP(NSTEP)) u_cordic_y (
    .clk(clk), .en(en), .phi(phi_y), .cos_o(cy), .sin_o(sy)
  );
  euq_cordic #(.NSTEP(NSTEP)) u_cordic_z (
    .clk(clk), .en(en), .phi(phi_z), .cos_o(cz), .sin_o(sz)
  );

  euq_quat u_quat (
    .clk(clk), .rst_n(rst_n), .en(en), .ctl_in(ctl_r[NSTEP-1]),
    .cx(cx), .sx(sx), .cy(cy), .sy(sy), .cz(cz), .sz(sz),
    .ctl_out(ctl_q),
    .quat_w(out_quat_w), .quat_x(out_quat_x),
    .quat_y(out_quat_y), .quat_z(out_quat_z)
  );

  assign out_valid     = ctl_q.vld;
  assign out_valid_res = ctl_q.ok;

  // refused beats carry zero components
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |->
      (out_quat_w == 16'sd0 && out_quat_x == 16'sd0 &&
       out_quat_y == 16'sd0 && out_quat_z == 16'sd0))
    else $error("refused beat with nonzero quaternion");

  // saturation keeps the w and x components within unit range
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_w <= euq_pkg::Q14_ONE && out_quat_w >= -euq_pkg::Q14_ONE &&
                   out_quat_x <= euq_pkg::Q14_ONE && out_quat_x >= -euq_pkg::Q14_ONE))
    else $error("quaternion component out of range");

  // a stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_quat_w) &&
                                   $stable(out_valid_res)))
    else $error("stalled result changed");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
